### rtl/obc_pkg.sv
// Package: shared types, constants and helper functions of the offset base-128 codec.
`timescale 1ns / 1ps
package obc_pkg;

  // Function codes of an input word
  localparam logic FUNC_ENC = 1'b0;
  localparam logic FUNC_DEC = 1'b1;

  localparam int          NUM_BYTES   = 5;
  localparam logic [7:0]  CODE_OFFSET = 8'd32;
  localparam logic [7:0]  DIGIT_MAX   = 8'd223;
  localparam logic [7:0]  TOP5_MAX    = 8'd15;
  localparam logic [2:0]  WIDTH_MIN   = 3'd1;
  localparam logic [2:0]  WIDTH_MAX   = 3'd5;

  // One pipeline stage's word
  typedef struct packed {
    logic                        valid;
    logic                        func;
    logic [2:0]                  width;
    logic                        width_ok;
    logic [31:0]                 t;        // remaining value while encoding
    logic [NUM_BYTES-1:0][7:0]   bytes;    // code bytes, index 0 most significant
    logic [31:0]                 dec_hi;   // partial sum, later the decoded sum
    logic [31:0]                 dec_lo;
  } obc_stage_t;

  // Saturation cap per width
  function automatic logic [31:0] sat_cap(input logic [2:0] w);
    logic [31:0] c;
    unique case (w)
      3'd1:    c = 32'd223;
      3'd2:    c = 32'd28767;
      3'd3:    c = 32'd3682399;
      3'd4:    c = 32'd471347295;
      3'd5:    c = 32'hFFFF_FFFF;
      default: c = 32'd0;
    endcase
    return c;
  endfunction

  // Combined decode offset per width
  function automatic logic [31:0] dec_offset(input logic [2:0] w);
    logic [31:0] c;
    unique case (w)
      3'd1:         c = 32'h20;
      3'd2:         c = 32'h1020;
      3'd3:         c = 32'h81020;
      3'd4, 3'd5:   c = 32'h4081020;
      default:      c = 32'd0;
    endcase
    return c;
  endfunction

  // Bit position of digit i at width w; zero where the digit is not weighted
  function automatic logic [4:0] shift_amt(input logic [2:0] w, input int i);
    int s;
    s = 7 * (int'(w) - 1 - i);
    if (s < 0) s = 0;
    return s[4:0];
  endfunction

endpackage

### rtl/obc_front.sv
// Front stage: truncation and saturation for encode, partial weighted sums for decode.
`timescale 1ns / 1ps
module obc_front import obc_pkg::*; (
  input  logic                       start,
  input  logic                       in_func,
  input  logic [2:0]                 in_width,
  input  logic [31:0]                in_value,
  input  logic [NUM_BYTES-1:0][7:0]  in_bytes,
  output obc_stage_t                 front
);

  logic [31:0]                 trunc;
  logic [31:0]                 cap;
  logic [NUM_BYTES-1:0][31:0]  term;

  // Truncate to the narrow types, then clamp to the width's maximum
  always_comb begin
    unique case (in_width)
      3'd1:    trunc = {24'd0, in_value[7:0]};
      3'd2:    trunc = {16'd0, in_value[15:0]};
      default: trunc = in_value;
    endcase
    cap = sat_cap(in_width);
  end

  // Weighted code bytes; bytes beyond the width are dropped
  always_comb begin
    for (int i = 0; i < NUM_BYTES; i++) begin
      if (3'(i) < in_width) begin
        term[i] = {24'd0, in_bytes[i]} << shift_amt(in_width, i);
      end else begin
        term[i] = 32'd0;
      end
    end
  end

  always_comb begin
    front.valid    = start;
    front.func     = in_func;
    front.width    = in_width;
    front.width_ok = (in_width >= WIDTH_MIN) && (in_width <= WIDTH_MAX);
    front.t        = (trunc > cap) ? cap : trunc;
    front.bytes    = '0;
    front.dec_hi   = term[0] + term[1] + term[2];
    front.dec_lo   = term[3] + term[4];
  end

endmodule

### rtl/obc_digit.sv
// One encode digit step: take an 8-bit window, clamp it, subtract it, emit its code byte.
`timescale 1ns / 1ps
module obc_digit import obc_pkg::*; (
  input  logic [1:0]  idx,
  input  obc_stage_t  s_in,
  output obc_stage_t  s_out
);

  logic        active;
  logic        top5;
  logic [4:0]  sh;
  logic [7:0]  win;
  logic [7:0]  lim;
  logic [7:0]  d;

  always_comb begin
    active = (({1'b0, idx} + 3'd1) < s_in.width) && (s_in.func == FUNC_ENC);
    top5   = (s_in.width == WIDTH_MAX) && (idx == 2'd0);
    sh     = shift_amt(s_in.width, int'(idx));
    win    = 8'(s_in.t >> sh);
    lim    = top5 ? TOP5_MAX : DIGIT_MAX;
    d      = (win > lim) ? lim : win;

    s_out = s_in;
    if (active) begin
      s_out.t                    = s_in.t - ({24'd0, d} << sh);
      s_out.bytes[{1'b0, idx}]   = top5 ? d : (d + CODE_OFFSET);
    end
  end

endmodule

### rtl/offset_base128_int_codec_unit.sv
// Top level: four-stage pipelined offset base-128 encoder and decoder.
//
//   channel | ports                                        | handshake
//   --------+----------------------------------------------+--------------------------
//   input   | in_func in_width in_value in_byte0..in_byte4 | start && !busy
//   result  | out_byte0..out_byte4 out_decoded_value       | out_valid, one cycle
//
// One word enters per cycle; busy never rises. Four register stages (front,
// two digit stages, output register) sit between input and result. The four
// dependent digit steps are split two per stage. Reset is synchronous,
// active low, and clears every stage. The receiver cannot stall, so the
// pipeline never holds.
`timescale 1ns / 1ps
module offset_base128_int_codec_unit import obc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  logic         in_func,
  input  logic [2:0]   in_width,
  input  logic [31:0]  in_value,
  input  logic [7:0]   in_byte0,
  input  logic [7:0]   in_byte1,
  input  logic [7:0]   in_byte2,
  input  logic [7:0]   in_byte3,
  input  logic [7:0]   in_byte4,
  output logic         out_valid,
  output logic [7:0]   out_byte0,
  output logic [7:0]   out_byte1,
  output logic [7:0]   out_byte2,
  output logic [7:0]   out_byte3,
  output logic [7:0]   out_byte4,
  output logic [31:0]  out_decoded_value
);

  obc_stage_t                 front;
  obc_stage_t                 s1_r, s2_r, s3_r;
  obc_stage_t                 d0, d1, d2, d3;
  obc_stage_t                 s3_nxt;
  logic [NUM_BYTES-1:0][7:0]  out_bytes_r, out_bytes_nxt;
  logic [31:0]                out_dec_r, out_dec_nxt;
  logic                       out_valid_r;

  assign busy = 1'b0;

  obc_front u_front (
    .start    (start),
    .in_func  (in_func),
    .in_width (in_width),
    .in_value (in_value),
    .in_bytes ({in_byte4, in_byte3, in_byte2, in_byte1, in_byte0}),
    .front    (front)
  );

  // Stage 2: top two digits
  obc_digit u_dig0 (.idx(2'd0), .s_in(s1_r), .s_out(d0));
  obc_digit u_dig1 (.idx(2'd1), .s_in(d0),   .s_out(d1));

  // Stage 3: next two digits
  obc_digit u_dig2 (.idx(2'd2), .s_in(s2_r), .s_out(d2));
  obc_digit u_dig3 (.idx(2'd3), .s_in(d2),   .s_out(d3));

  // Stage 3 also: last byte from the remainder, decode offset removed
  always_comb begin
    s3_nxt = d3;
    if (d3.func == FUNC_ENC) begin
      for (int j = 0; j < NUM_BYTES; j++) begin
        if (3'(j + 1) == d3.width) begin
          s3_nxt.bytes[j] = d3.t[7:0] + CODE_OFFSET;
        end
      end
    end
    s3_nxt.dec_hi = d3.dec_hi + d3.dec_lo - dec_offset(d3.width);
  end

  // Output stage: sign extension for short decodes, zeroing of unused fields
  always_comb begin
    out_bytes_nxt = '0;
    out_dec_nxt   = '0;
    if (s3_r.width_ok) begin
      if (s3_r.func == FUNC_ENC) begin
        out_bytes_nxt = s3_r.bytes;
      end else begin
        unique case (s3_r.width)
          3'd1:    out_dec_nxt = {{24{s3_r.dec_hi[7]}}, s3_r.dec_hi[7:0]};
          3'd2:    out_dec_nxt = {{16{s3_r.dec_hi[15]}}, s3_r.dec_hi[15:0]};
          default: out_dec_nxt = s3_r.dec_hi;
        endcase
      end
    end
  end

  // Pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r        <= '0;
      s2_r        <= '0;
      s3_r        <= '0;
      out_bytes_r <= '0;
      out_dec_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_r        <= front;
      s2_r        <= d1;
      s3_r        <= s3_nxt;
      out_bytes_r <= out_bytes_nxt;
      out_dec_r   <= out_dec_nxt;
      out_valid_r <= s3_r.valid;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte0         = out_bytes_r[0];
  assign out_byte1         = out_bytes_r[1];
  assign out_byte2         = out_bytes_r[2];
  assign out_byte3         = out_bytes_r[3];
  assign out_byte4         = out_bytes_r[4];
  assign out_decoded_value = out_dec_r;

endmodule

### rtl/obc_checker.sv
// Port checker for the codec top level, attached by bind.
`timescale 1ns / 1ps
module obc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         start,
  input logic         busy,
  input logic         out_valid,
  input logic [7:0]   out_byte0,
  input logic [7:0]   out_byte1,
  input logic [7:0]   out_byte2,
  input logic [7:0]   out_byte3,
  input logic [7:0]   out_byte4,
  input logic [31:0]  out_decoded_value
);

  // Every accepted word yields its result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("accepted word produced no result after four cycles");

  // No result without a matching accepted word
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("result strobe without a matching accepted word");

  // A nonzero decoded value comes only with all code bytes zero
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_decoded_value != 32'd0)) |->
      ((out_byte0 == 8'd0) && (out_byte1 == 8'd0) && (out_byte2 == 8'd0) &&
       (out_byte3 == 8'd0) && (out_byte4 == 8'd0)))
    else $error("encode bytes and decoded value both nonzero");

  // Pipeline empties on reset
  a_reset_clear: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result strobe straight after reset");

endmodule

bind offset_base128_int_codec_unit obc_checker u_obc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_byte0         (out_byte0),
  .out_byte1         (out_byte1),
  .out_byte2         (out_byte2),
  .out_byte3         (out_byte3),
  .out_byte4         (out_byte4),
  .out_decoded_value (out_decoded_value)
);

### tb/sv/tb_offset_base128_int_codec_unit.sv
// Testbench: offset base-128 codec unit checked word by word against a local predictor.
`timescale 1ns / 1ps
module tb_offset_base128_int_codec_unit import obc_pkg::*;;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int PRINT_LIMIT  = 100;
  localparam int TAIL_CYCLES  = 16;

  // One input word and one result word
  typedef struct packed {
    logic                      func;
    logic [2:0]                width;
    logic [31:0]               value;
    logic [NUM_BYTES-1:0][7:0] code;   // index 0 is the most significant byte
  } codec_word_t;

  typedef struct packed {
    logic [NUM_BYTES-1:0][7:0] code;
    logic [31:0]               value;
  } codec_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_func = 1'b0;
  logic [2:0]  in_width = 3'd0;
  logic [31:0] in_value = 32'd0;
  logic [7:0]  in_byte0 = 8'd0;
  logic [7:0]  in_byte1 = 8'd0;
  logic [7:0]  in_byte2 = 8'd0;
  logic [7:0]  in_byte3 = 8'd0;
  logic [7:0]  in_byte4 = 8'd0;
  logic        out_valid;
  logic [7:0]  out_byte0;
  logic [7:0]  out_byte1;
  logic [7:0]  out_byte2;
  logic [7:0]  out_byte3;
  logic [7:0]  out_byte4;
  logic [31:0] out_decoded_value;

  codec_word_t pending_words[$];
  codec_res_t  conv_expected[$];
  codec_word_t word_on_bus;
  int          idle_pct = 0;
  int          words_queued = 0;
  int          words_taken = 0;
  int          mismatches = 0;
  int          cycle_count = 0;

  offset_base128_int_codec_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_width          (in_width),
    .in_value          (in_value),
    .in_byte0          (in_byte0),
    .in_byte1          (in_byte1),
    .in_byte2          (in_byte2),
    .in_byte3          (in_byte3),
    .in_byte4          (in_byte4),
    .out_valid         (out_valid),
    .out_byte0         (out_byte0),
    .out_byte1         (out_byte1),
    .out_byte2         (out_byte2),
    .out_byte3         (out_byte3),
    .out_byte4         (out_byte4),
    .out_decoded_value (out_decoded_value)
  );

  // Clock
  always #2 clk = ~clk;

  // Largest number each width can carry; zero for widths with no code
  function automatic logic [31:0] width_ceiling(input logic [2:0] w);
    case (w)
      3'd1:    return 32'd223;
      3'd2:    return 32'd28767;
      3'd3:    return 32'd3682399;
      3'd4:    return 32'd471347295;
      3'd5:    return 32'hFFFF_FFFF;
      default: return 32'd0;
    endcase
  endfunction

  // Predicted result of one conversion
  function automatic codec_res_t predict_conversion(input codec_word_t w);
    codec_res_t  r;
    logic [31:0] t;
    logic [31:0] d;
    logic [31:0] lim;
    logic [31:0] acc;
    int          n;
    int          sh;
    int          i;
    r = '0;
    n = int'(w.width);
    if (n < 1 || n > 5) return r;
    if (w.func == FUNC_ENC) begin
      t = w.value;
      // narrow widths see only the low bits of the number
      if (n == 1) t = t & 32'hFF;
      if (n == 2) t = t & 32'hFFFF;
      if (t > width_ceiling(w.width)) t = width_ceiling(w.width);
      // upper digits top down, clamped; top byte at width five has no offset
      for (i = 0; i < n - 1; i++) begin
        sh  = 7 * (n - 1 - i);
        lim = (n == 5 && i == 0) ? 32'(TOP5_MAX) : 32'(DIGIT_MAX);
        d   = (t >> sh) & 32'hFF;
        if (d > lim) d = lim;
        t = t - (d << sh);
        r.code[i] = (n == 5 && i == 0) ? d[7:0] : d[7:0] + CODE_OFFSET;
      end
      r.code[n-1] = t[7:0] + CODE_OFFSET;
    end else begin
      acc = 32'd0;
      for (i = 0; i < n; i++) acc = (acc << 7) + 32'(w.code[i]);
      case (n)
        1:       acc = acc - 32'h20;
        2:       acc = acc - 32'h1020;
        3:       acc = acc - 32'h81020;
        default: acc = acc - 32'h4081020;
      endcase
      if (n == 1) acc = {{24{acc[7]}}, acc[7:0]};
      if (n == 2) acc = {{16{acc[15]}}, acc[15:0]};
      r.value = acc;
    end
    return r;
  endfunction

  function automatic codec_word_t make_word(input logic f, input logic [2:0] w,
                                            input logic [31:0] v, input logic [7:0] b0,
                                            input logic [7:0] b1, input logic [7:0] b2,
                                            input logic [7:0] b3, input logic [7:0] b4);
    codec_word_t x;
    x.func  = f;
    x.width = w;
    x.value = v;
    x.code  = '0;
    x.code[0] = b0;
    x.code[1] = b1;
    x.code[2] = b2;
    x.code[3] = b3;
    x.code[4] = b4;
    return x;
  endfunction

  // Random word: values clustered round the saturation points, decodes
  // mostly from well-formed codes, the odd unusable width mixed in
  function automatic codec_word_t random_word();
    codec_word_t x;
    codec_res_t  enc;
    logic [31:0] cap;
    int          i;
    x.func = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 4) begin
      case ($urandom_range(0, 2))
        0:       x.width = 3'd0;
        1:       x.width = 3'd6;
        default: x.width = 3'd7;
      endcase
    end else begin
      x.width = 3'($urandom_range(1, 5));
    end
    cap = width_ceiling(x.width);
    case ($urandom_range(0, 4))
      0:       x.value = $urandom;
      1:       x.value = cap - $urandom_range(0, 64);
      2:       x.value = cap + $urandom_range(1, 64);
      3:       x.value = $urandom_range(0, cap);
      default: x.value = ($urandom & 32'hFFFF_0000) |
                         32'((cap[15:0] + 16'($urandom_range(0, 40))) - 16'd20);
    endcase
    for (i = 0; i < NUM_BYTES; i++) x.code[i] = 8'($urandom_range(0, 255));
    if (x.func == FUNC_DEC && $urandom_range(0, 99) < 60) begin
      // well-formed code: encode a number, keep the noise beyond the width
      x.func = FUNC_ENC;
      enc = predict_conversion(x);
      for (i = 0; i < int'(x.width) && i < NUM_BYTES; i++) x.code[i] = enc.code[i];
      x.func = FUNC_DEC;
      x.value = $urandom;
    end
    return x;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Appends one word to the driver's queue
  task automatic queue_word(input codec_word_t x);
    pending_words.insert(pending_words.size(), x);
    words_queued++;
  endtask

  // Waits until every queued word is taken and every result has come back
  task automatic drain_all();
    while (words_taken != words_queued || conv_expected.size() != 0) @(posedge clk);
  endtask

  task automatic run_random_phase(input int pct, input int count);
    idle_pct = pct;
    repeat (count) queue_word(random_word());
    drain_all();
  endtask

  // Driver: offers the next word, or noise with start low while idle
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        conv_expected.insert(conv_expected.size(), predict_conversion(word_on_bus));
        words_taken++;
      end
      if (!start || !busy) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          word_on_bus = pending_words.pop_front();
          start    <= 1'b1;
          in_func  <= word_on_bus.func;
          in_width <= word_on_bus.width;
          in_value <= word_on_bus.value;
          in_byte0 <= word_on_bus.code[0];
          in_byte1 <= word_on_bus.code[1];
          in_byte2 <= word_on_bus.code[2];
          in_byte3 <= word_on_bus.code[3];
          in_byte4 <= word_on_bus.code[4];
        end else begin
          start    <= 1'b0;
          in_func  <= 1'($urandom_range(0, 1));
          in_width <= 3'($urandom_range(0, 7));
          in_value <= $urandom;
          in_byte0 <= 8'($urandom_range(0, 255));
          in_byte1 <= 8'($urandom_range(0, 255));
          in_byte2 <= 8'($urandom_range(0, 255));
          in_byte3 <= 8'($urandom_range(0, 255));
          in_byte4 <= 8'($urandom_range(0, 255));
        end
      end
    end
  end

  // Monitor: each result word against the oldest prediction
  always @(posedge clk) begin
    codec_res_t want;
    if (rst_n && out_valid) begin
      if (conv_expected.size() == 0) begin
        report_mismatch("result with nothing outstanding", out_decoded_value, 32'd0);
      end else begin
        want = conv_expected.pop_front();
        if (out_byte0 !== want.code[0])
          report_mismatch("out_byte0", 32'(out_byte0), 32'(want.code[0]));
        if (out_byte1 !== want.code[1])
          report_mismatch("out_byte1", 32'(out_byte1), 32'(want.code[1]));
        if (out_byte2 !== want.code[2])
          report_mismatch("out_byte2", 32'(out_byte2), 32'(want.code[2]));
        if (out_byte3 !== want.code[3])
          report_mismatch("out_byte3", 32'(out_byte3), 32'(want.code[3]));
        if (out_byte4 !== want.code[4])
          report_mismatch("out_byte4", 32'(out_byte4), 32'(want.code[4]));
        if (out_decoded_value !== want.value)
          report_mismatch("out_decoded_value", out_decoded_value, want.value);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 0;
    // encode: zero, the saturation points, just above them, truncation at narrow widths
    queue_word(make_word(FUNC_ENC, 3'd1, 32'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    queue_word(make_word(FUNC_ENC, 3'd1, 32'd223, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    queue_word(make_word(FUNC_ENC, 3'd1, 32'd224, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    queue_word(make_word(FUNC_ENC, 3'd1, 32'h1FF, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    queue_word(make_word(FUNC_ENC, 3'd1, 32'hFFFF_FF00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    queue_word(make_word(FUNC_ENC, 3'd2, 32'd28767, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    queue_word(make_word(FUNC_ENC, 3'd2, 32'd28768, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    queue_word(make_word(FUNC_ENC, 3'd2, 32'h1_FFFF, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    queue_word(make_word(FUNC_ENC, 3'd3, 32'd3682399, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    queue_word(make_word(FUNC_ENC, 3'd3, 32'd3682400, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    queue_word(make_word(FUNC_ENC, 3'd4, 32'd471347295, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    queue_word(make_word(FUNC_ENC, 3'd4, 32'hFFFF_FFFF, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    queue_word(make_word(FUNC_ENC, 3'd5, 32'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    queue_word(make_word(FUNC_ENC, 3'd5, 32'hFFFF_FFFF, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    queue_word(make_word(FUNC_ENC, 3'd5, 32'h7FFF_FFFF, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    // decode: all-zero and all-ones bytes, sign extension at narrow widths
    queue_word(make_word(FUNC_DEC, 3'd1, 32'hFFFF_FFFF, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    queue_word(make_word(FUNC_DEC, 3'd1, 32'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    queue_word(make_word(FUNC_DEC, 3'd2, 32'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
    queue_word(make_word(FUNC_DEC, 3'd2, 32'd0, 8'd32, 8'd32, 8'd255, 8'd255, 8'd255));
    queue_word(make_word(FUNC_DEC, 3'd3, 32'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255));
    queue_word(make_word(FUNC_DEC, 3'd4, 32'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0));
    queue_word(make_word(FUNC_DEC, 3'd5, 32'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    queue_word(make_word(FUNC_DEC, 3'd5, 32'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    // unusable widths give all-zero outputs for both functions
    queue_word(make_word(FUNC_ENC, 3'd0, 32'hFFFF_FFFF,
                         8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    queue_word(make_word(FUNC_DEC, 3'd6, 32'hFFFF_FFFF,
                         8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    queue_word(make_word(FUNC_DEC, 3'd7, 32'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    drain_all();

    // random phases; each drains fully before the next, so the sender
    // pauses until every result is back
    run_random_phase(0, 500);
    run_random_phase(88, 400);
    run_random_phase(10, 300);
    run_random_phase(0, 250);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### offset_base128_int_codec_unit.f
rtl/obc_pkg.sv
rtl/obc_front.sv
rtl/obc_digit.sv
rtl/offset_base128_int_codec_unit.sv
rtl/obc_checker.sv
tb/sv/tb_offset_base128_int_codec_unit.sv
